@@ rtl/assert_macros.svh @@
// assertion macros shared by the ray triangle rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define RTN_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// assertion on the block clock and reset
`define RTN_ASSERT(lbl, prop, msg) \
    `RTN_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

@@ rtl/rtn_pkg.sv @@
// shared types, constants and step table of the ray triangle nearest hit block
package rtn_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TILE_W     = 8;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SH_W       = PROD_W - FRAC_BITS;
    localparam int ACC_W      = SH_W + 2;
    localparam int T_W        = 31;
    localparam int T_INT_BITS = T_W - FRAC_BITS;
    localparam int NUM_STEPS  = 27;
    localparam int STEP_W     = $clog2(NUM_STEPS);
    localparam int TN_STEP    = 23;
    localparam int PT_STEP    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_CNT_W  = $clog2(T_W + 1);
    localparam int FACE_W     = 3;
    localparam int SLOT_W     = 2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] vec3_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [ACC_W:0] wide_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORG_X = 3'd0,
        REG_ORG_Y = 3'd1,
        REG_ORG_Z = 3'd2,
        REG_DIR_X = 3'd3,
        REG_DIR_Y = 3'd4,
        REG_DIR_Z = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        GRP_D, GRP_E1, GRP_E2, GRP_TV, GRP_P, GRP_Q, GRP_T
    } grp_t;

    typedef enum logic [1:0] {
        ACC_LOAD, ACC_ADD, ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        DST_NONE, DST_P, DST_Q, DST_DET, DST_UN, DST_VN, DST_TN, DST_PT
    } dst_t;

    typedef enum logic [1:0] {
        CHK_NONE, CHK_DET, CHK_UN, CHK_VN
    } chk_t;

    typedef struct packed {
        grp_t       a_grp;
        logic [1:0] a_idx;
        grp_t       b_grp;
        logic [1:0] b_idx;
        acc_op_t    op;
        dst_t       dst;
        logic [1:0] dst_idx;
        chk_t       chk;
    } step_t;

    typedef struct packed {
        logic    mul_en;
        logic    acc_en;
        acc_op_t op;
    } mac_ctrl_t;

    function automatic step_t mk(input grp_t ag, input logic [1:0] ai, input grp_t bg,
                                 input logic [1:0] bi, input acc_op_t op, input dst_t d,
                                 input logic [1:0] di, input chk_t c);
        step_t r;
        r.a_grp   = ag;
        r.a_idx   = ai;
        r.b_grp   = bg;
        r.b_idx   = bi;
        r.op      = op;
        r.dst     = d;
        r.dst_idx = di;
        r.chk     = c;
        return r;
    endfunction

    // p = dir x e2, det, un, q = tv x e1, vn, tn, hit point
    function automatic step_t step_of(input logic [STEP_W-1:0] s);
        step_t r;
        r = mk(GRP_D, 2'd0, GRP_D, 2'd0, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
        case (s)
            0:  r = mk(GRP_D, 2'd1, GRP_E2, 2'd2, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
            1:  r = mk(GRP_D, 2'd2, GRP_E2, 2'd1, ACC_SUB, DST_P, 2'd0, CHK_NONE);
            2:  r = mk(GRP_D, 2'd2, GRP_E2, 2'd0, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
            3:  r = mk(GRP_D, 2'd0, GRP_E2, 2'd2, ACC_SUB, DST_P, 2'd1, CHK_NONE);
            4:  r = mk(GRP_D, 2'd0, GRP_E2, 2'd1, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
            5:  r = mk(GRP_D, 2'd1, GRP_E2, 2'd0, ACC_SUB, DST_P, 2'd2, CHK_NONE);
            6:  r = mk(GRP_E1, 2'd0, GRP_P, 2'd0, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
            7:  r = mk(GRP_E1, 2'd1, GRP_P, 2'd1, ACC_ADD, DST_NONE, 2'd0, CHK_NONE);
            8:  r = mk(GRP_E1, 2'd2, GRP_P, 2'd2, ACC_ADD, DST_DET, 2'd0, CHK_NONE);
            9:  r = mk(GRP_TV, 2'd0, GRP_P, 2'd0, ACC_LOAD, DST_NONE, 2'd0, CHK_DET);
            10: r = mk(GRP_TV, 2'd1, GRP_P, 2'd1, ACC_ADD, DST_NONE, 2'd0, CHK_NONE);
            11: r = mk(GRP_TV, 2'd2, GRP_P, 2'd2, ACC_ADD, DST_UN, 2'd0, CHK_NONE);
            12: r = mk(GRP_TV, 2'd1, GRP_E1, 2'd2, ACC_LOAD, DST_NONE, 2'd0, CHK_UN);
            13: r = mk(GRP_TV, 2'd2, GRP_E1, 2'd1, ACC_SUB, DST_Q, 2'd0, CHK_NONE);
            14: r = mk(GRP_TV, 2'd2, GRP_E1, 2'd0, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
            15: r = mk(GRP_TV, 2'd0, GRP_E1, 2'd2, ACC_SUB, DST_Q, 2'd1, CHK_NONE);
            16: r = mk(GRP_TV, 2'd0, GRP_E1, 2'd1, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
            17: r = mk(GRP_TV, 2'd1, GRP_E1, 2'd0, ACC_SUB, DST_Q, 2'd2, CHK_NONE);
            18: r = mk(GRP_D, 2'd0, GRP_Q, 2'd0, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
            19: r = mk(GRP_D, 2'd1, GRP_Q, 2'd1, ACC_ADD, DST_NONE, 2'd0, CHK_NONE);
            20: r = mk(GRP_D, 2'd2, GRP_Q, 2'd2, ACC_ADD, DST_VN, 2'd0, CHK_NONE);
            21: r = mk(GRP_E2, 2'd0, GRP_Q, 2'd0, ACC_LOAD, DST_NONE, 2'd0, CHK_VN);
            22: r = mk(GRP_E2, 2'd1, GRP_Q, 2'd1, ACC_ADD, DST_NONE, 2'd0, CHK_NONE);
            23: r = mk(GRP_E2, 2'd2, GRP_Q, 2'd2, ACC_ADD, DST_TN, 2'd0, CHK_NONE);
            24: r = mk(GRP_D, 2'd0, GRP_T, 2'd0, ACC_LOAD, DST_PT, 2'd0, CHK_NONE);
            25: r = mk(GRP_D, 2'd1, GRP_T, 2'd0, ACC_LOAD, DST_PT, 2'd1, CHK_NONE);
            26: r = mk(GRP_D, 2'd2, GRP_T, 2'd0, ACC_LOAD, DST_PT, 2'd2, CHK_NONE);
            default: r = mk(GRP_D, 2'd0, GRP_D, 2'd0, ACC_LOAD, DST_NONE, 2'd0, CHK_NONE);
        endcase
        return r;
    endfunction

    function automatic wide_t widen(input coord_t x);
        logic signed [COORD_W-1:0] xs;
        xs = signed'(x);
        return (ACC_W + 1)'(xs);
    endfunction

    function automatic coord_t sat_coord(input wide_t x);
        wide_t hi;
        wide_t lo;
        hi = {{(ACC_W + 2 - COORD_W){1'b0}}, {(COORD_W - 1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[COORD_W-1:0];
        end else if (x < lo) begin
            return lo[COORD_W-1:0];
        end
        return x[COORD_W-1:0];
    endfunction

endpackage

@@ rtl/rtn_mac.sv @@
// shared multiply with floor shift and accumulate unit
module rtn_mac import rtn_pkg::*; (
    input  logic                      aclk,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [COORD_W-1:0] op_a,
    input  logic signed [COORD_W-1:0] op_b,
    output acc_t                      acc_next
);

    logic signed [PROD_W-1:0] prod_reg;
    acc_t                     acc_reg;
    logic signed [SH_W-1:0]   sh;
    acc_t                     sh_ext;

    assign sh     = prod_reg[PROD_W-1:FRAC_BITS];
    assign sh_ext = ACC_W'(sh);

    always_comb begin
        case (ctrl.op)
            ACC_LOAD: acc_next = sh_ext;
            ACC_ADD:  acc_next = acc_reg + sh_ext;
            ACC_SUB:  acc_next = acc_reg - sh_ext;
            default:  acc_next = sh_ext;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ rtl/rtn_div.sv @@
// bit serial fixed point divider with saturation for the ray parameter
`include "assert_macros.svh"

module rtn_div import rtn_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ACC_W-1:0] num,
    input  logic [ACC_W-1:0] den,
    output logic             done,
    output logic [T_W-1:0]   quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0]     rem_reg;
    logic [ACC_W-1:0]     den_reg;
    logic [T_W-1:0]       nbits_reg;
    logic [T_W-1:0]       quot_reg;
    logic [ACC_W-1:0]     rem_init;
    logic [ACC_W:0]       rem2;
    logic [ACC_W:0]       rem2_sub;
    logic                 take;

    assign rem_init = num >> T_INT_BITS;
    assign rem2     = {rem_reg, nbits_reg[T_W-1]};
    assign rem2_sub = rem2 - {1'b0, den_reg};
    assign take     = rem2 >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quot     = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= start ? (rem_init >= den)
                              : (busy_reg && cnt_reg == DIV_CNT_W'(1));
            if (start) begin
                den_reg   <= den;
                rem_reg   <= rem_init;
                nbits_reg <= {num[T_INT_BITS-1:0], {FRAC_BITS{1'b0}}};
                if (rem_init >= den) begin
                    quot_reg <= '1;
                end else begin
                    quot_reg <= '0;
                    busy_reg <= 1'b1;
                    cnt_reg  <= DIV_CNT_W'(T_W);
                end
            end else if (busy_reg) begin
                nbits_reg <= nbits_reg << 1;
                if (take) begin
                    rem_reg  <= rem2_sub[ACC_W-1:0];
                    quot_reg <= {quot_reg[T_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem2[ACC_W-1:0];
                    quot_reg <= {quot_reg[T_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    `RTN_ASSERT(a_div_cnt_range, busy_reg |-> (cnt_reg != '0 && cnt_reg <= DIV_CNT_W'(T_W)), "divider count out of range")
    `RTN_ASSERT(a_div_done_idle, done_reg |-> !busy_reg, "divider done while busy")

endmodule

@@ rtl/ray_triangle_nearest_hit.sv @@
// ray triangle nearest hit top level: sequencer, operand registers and result register
//
// Usage: the ray origin and direction are written through the cfg channel (index 0..5,
// origin x/y/z then direction x/y/z, Q16.16) while the block is idle. Triangles stream in
// on the s_ channel one corner per item; the corner 2 item carries the tile and face tags
// and starts the test of the triangle. The item with s_last_triangle high produces one
// result on the m_ channel with the nearest hit, then the kept hit is cleared.
// Corner 0 and 1 items are stored while idle. A corner 2 item runs 27 steps of one
// shared 32x32 multiplier, each a multiply and an accumulate state, plus a one bit per
// cycle divider for the 31 bit quotient; a triangle rejected early runs fewer steps.
// s_ready is high only while the sequencer is idle. A result sits in an output register;
// the block keeps taking items while it waits, and stalls only when a further result is
// ready and the receiver has not taken the previous one.
// Reset (aresetn low, synchronous) clears the ray registers and stored corners to zero,
// the kept hit to none and drops m_valid.
`include "assert_macros.svh"

module ray_triangle_nearest_hit import rtn_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SLOT_W-1:0]         s_vertex_slot,
    input  logic signed [COORD_W-1:0] s_vert_x,
    input  logic signed [COORD_W-1:0] s_vert_y,
    input  logic signed [COORD_W-1:0] s_vert_z,
    input  logic [TILE_W-1:0]         s_tri_tile_x,
    input  logic [TILE_W-1:0]         s_tri_tile_y,
    input  logic [FACE_W-1:0]         s_tri_face,
    input  logic                      s_last_triangle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_found,
    output logic [T_W-1:0]            m_hit_t,
    output logic signed [COORD_W-1:0] m_hit_px,
    output logic signed [COORD_W-1:0] m_hit_py,
    output logic signed [COORD_W-1:0] m_hit_pz,
    output logic signed [TILE_W:0]    m_hit_tile_x,
    output logic signed [TILE_W:0]    m_hit_tile_y,
    output logic [FACE_W-1:0]         m_hit_face
);

    localparam logic [SLOT_W-1:0] SLOT_C2   = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EDGE, ST_MUL, ST_ACC, ST_DIVS, ST_DIVW, ST_FIN, ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    vec3_t               org_reg;
    vec3_t               dir_reg;
    vec3_t               vtx_reg [3];
    vec3_t               e1_reg;
    vec3_t               e2_reg;
    vec3_t               tv_reg;
    vec3_t               p_reg;
    vec3_t               q_reg;
    vec3_t               e1_next;
    vec3_t               e2_next;
    vec3_t               tv_next;
    acc_t                det_reg;
    acc_t                un_reg;
    acc_t                vn_reg;
    acc_t                tn_reg;
    logic [T_W-1:0]      t_reg;
    logic [TILE_W-1:0]   tag_x_reg;
    logic [TILE_W-1:0]   tag_y_reg;
    logic [FACE_W-1:0]   tag_face_reg;
    logic                last_reg;
    logic [COORD_W-1:0]  best_t_reg;
    logic signed [TILE_W:0] best_tile_x_reg;
    logic signed [TILE_W:0] best_tile_y_reg;
    logic [FACE_W-1:0]   best_face_reg;
    logic                hit_seen_reg;
    vec3_t               best_pt_reg;
    logic                m_valid_reg;
    logic                m_found_reg;
    logic [T_W-1:0]      m_hit_t_reg;
    vec3_t               m_pt_reg;
    logic signed [TILE_W:0] m_tile_x_reg;
    logic signed [TILE_W:0] m_tile_y_reg;
    logic [FACE_W-1:0]   m_face_reg;

    step_t               cur;
    mac_ctrl_t           mac_ctrl;
    coord_t              op_a;
    coord_t              op_b;
    acc_t                acc_next;
    logic                reject;
    logic                div_start;
    logic                div_done;
    logic [T_W-1:0]      div_quot;
    logic                out_free;

    function automatic coord_t pick(input grp_t g, input logic [1:0] i, input vec3_t d,
                                    input vec3_t e1, input vec3_t e2, input vec3_t tv,
                                    input vec3_t p, input vec3_t q, input logic [T_W-1:0] t);
        vec3_t v;
        case (g)
            GRP_D:   v = d;
            GRP_E1:  v = e1;
            GRP_E2:  v = e2;
            GRP_TV:  v = tv;
            GRP_P:   v = p;
            GRP_Q:   v = q;
            GRP_T:   v = {3{COORD_W'(t)}};
            default: v = '0;
        endcase
        case (i)
            2'd0:    return v[0];
            2'd1:    return v[1];
            2'd2:    return v[2];
            default: return '0;
        endcase
    endfunction

    assign cur       = step_of(step_reg);
    assign op_a      = pick(cur.a_grp, cur.a_idx, dir_reg, e1_reg, e2_reg, tv_reg, p_reg,
                            q_reg, t_reg);
    assign op_b      = pick(cur.b_grp, cur.b_idx, dir_reg, e1_reg, e2_reg, tv_reg, p_reg,
                            q_reg, t_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign div_start = (state_reg == ST_DIVS) && (tn_reg > 0);

    always_comb begin
        mac_ctrl.mul_en = (state_reg == ST_MUL);
        mac_ctrl.acc_en = (state_reg == ST_ACC);
        mac_ctrl.op     = cur.op;
    end

    always_comb begin
        case (cur.chk)
            CHK_DET: reject = (det_reg <= 0);
            CHK_UN:  reject = (un_reg < 0) || (un_reg > det_reg);
            CHK_VN:  reject = (vn_reg < 0) ||
                              ((ACC_W + 1)'(un_reg) + (ACC_W + 1)'(vn_reg) >
                               (ACC_W + 1)'(det_reg));
            default: reject = 1'b0;
        endcase
    end

    // saturated edges and origin offset
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1_next[k] = sat_coord(widen(vtx_reg[1][k]) - widen(vtx_reg[0][k]));
            e2_next[k] = sat_coord(widen(vtx_reg[2][k]) - widen(vtx_reg[0][k]));
            tv_next[k] = sat_coord(widen(org_reg[k]) - widen(vtx_reg[0][k]));
        end
    end

    rtn_mac u_mac (
        .aclk     (aclk),
        .ctrl     (mac_ctrl),
        .op_a     (op_a),
        .op_b     (op_b),
        .acc_next (acc_next)
    );

    rtn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (tn_reg),
        .den     (det_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            org_reg         <= '0;
            dir_reg         <= '0;
            vtx_reg         <= '{default: '0};
            last_reg        <= 1'b0;
            best_t_reg      <= '1;
            best_tile_x_reg <= '1;
            best_tile_y_reg <= '1;
            best_face_reg   <= '0;
            hit_seen_reg    <= 1'b0;
            best_pt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_ORG_X: org_reg[0] <= cfg_data;
                    REG_ORG_Y: org_reg[1] <= cfg_data;
                    REG_ORG_Z: org_reg[2] <= cfg_data;
                    REG_DIR_X: dir_reg[0] <= cfg_data;
                    REG_DIR_Y: dir_reg[1] <= cfg_data;
                    REG_DIR_Z: dir_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_vertex_slot != SLOT_NONE) begin
                            vtx_reg[s_vertex_slot] <= {s_vert_z, s_vert_y, s_vert_x};
                        end
                        tag_x_reg    <= s_tri_tile_x;
                        tag_y_reg    <= s_tri_tile_y;
                        tag_face_reg <= s_tri_face;
                        last_reg     <= s_last_triangle;
                        if (s_vertex_slot == SLOT_C2) begin
                            state_reg <= ST_EDGE;
                        end else if (s_last_triangle) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EDGE: begin
                    e1_reg    <= e1_next;
                    e2_reg    <= e2_next;
                    tv_reg    <= tv_next;
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= reject ? ST_FIN : ST_ACC;
                end
                ST_ACC: begin
                    case (cur.dst)
                        DST_P:   p_reg[cur.dst_idx] <= sat_coord((ACC_W + 1)'(acc_next));
                        DST_Q:   q_reg[cur.dst_idx] <= sat_coord((ACC_W + 1)'(acc_next));
                        DST_DET: det_reg <= acc_next;
                        DST_UN:  un_reg  <= acc_next;
                        DST_VN:  vn_reg  <= acc_next;
                        DST_TN:  tn_reg  <= acc_next;
                        DST_PT:  best_pt_reg[cur.dst_idx] <=
                                     sat_coord(widen(org_reg[cur.dst_idx]) +
                                               (ACC_W + 1)'(acc_next));
                        default: ;
                    endcase
                    if (step_reg == STEP_W'(TN_STEP)) begin
                        state_reg <= ST_DIVS;
                    end else if (step_reg == STEP_W'(NUM_STEPS - 1)) begin
                        best_t_reg      <= COORD_W'(t_reg);
                        best_tile_x_reg <= (TILE_W + 1)'(tag_x_reg);
                        best_tile_y_reg <= (TILE_W + 1)'(tag_y_reg);
                        best_face_reg   <= tag_face_reg;
                        hit_seen_reg    <= 1'b1;
                        state_reg       <= ST_FIN;
                    end else begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIVS: begin
                    state_reg <= div_start ? ST_DIVW : ST_FIN;
                end
                ST_DIVW: begin
                    if (div_done) begin
                        if (div_quot == '0 || COORD_W'(div_quot) >= best_t_reg) begin
                            state_reg <= ST_FIN;
                        end else begin
                            t_reg     <= div_quot;
                            step_reg  <= STEP_W'(PT_STEP);
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_FIN: begin
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_found_reg     <= hit_seen_reg;
                        m_hit_t_reg     <= best_t_reg[T_W-1:0];
                        m_pt_reg        <= best_pt_reg;
                        m_tile_x_reg    <= best_tile_x_reg;
                        m_tile_y_reg    <= best_tile_y_reg;
                        m_face_reg      <= best_face_reg;
                        best_t_reg      <= '1;
                        best_tile_x_reg <= '1;
                        best_tile_y_reg <= '1;
                        best_face_reg   <= '0;
                        hit_seen_reg    <= 1'b0;
                        best_pt_reg     <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_hit_t      = m_hit_t_reg;
    assign m_hit_px     = m_pt_reg[0];
    assign m_hit_py     = m_pt_reg[1];
    assign m_hit_pz     = m_pt_reg[2];
    assign m_hit_tile_x = m_tile_x_reg;
    assign m_hit_tile_y = m_tile_y_reg;
    assign m_hit_face   = m_face_reg;

    `RTN_ASSERT(a_emit_clears, (state_reg == ST_EMIT && out_free) |=> (m_valid && !hit_seen_reg && best_t_reg == '1), "kept hit not cleared after result")
    `RTN_ASSERT(a_found_tiles, (m_valid && m_found) |-> (!m_hit_tile_x[TILE_W] && !m_hit_tile_y[TILE_W]), "hit result with negative tile")
    `RTN_ASSERT(a_step_range, (state_reg == ST_MUL || state_reg == ST_ACC) |-> (step_reg < STEP_W'(NUM_STEPS)), "step out of table")
    `RTN_ASSERT(a_div_done_wait, div_done |-> (state_reg == ST_DIVW), "divider result outside wait")

endmodule
